// File: rtl/core/ole_pkg.sv
package ole_pkg;

  // Command codes carried by an input word
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic       capture;     // a word is accepted this cycle
    cmd_t       cmd;
    logic [6:0] pos;
    logic [6:0] count;       // element count before the command
    logic       shift_up;    // insert succeeds
    logic       shift_down;  // remove succeeds
  } cell_ctrl_t;

endpackage

// File: rtl/core/ole_cell.sv
// One list entry: holds its element, takes a neighbour's element on a shift,
// and flags a match or a selected read against the broadcast command.
module ole_cell #(
  parameter int INDEX      = 0,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk,
  input  ole_pkg::cell_ctrl_t   ctrl,
  input  logic [ELEM_WIDTH-1:0] val,
  input  logic [ELEM_WIDTH-1:0] left_data,
  input  logic [ELEM_WIDTH-1:0] right_data,
  output logic [ELEM_WIDTH-1:0] data,
  output logic                  match,
  output logic [ELEM_WIDTH-1:0] rd
);

  localparam logic [31:0] IDX = 32'(INDEX);

  logic [ELEM_WIDTH-1:0] data_next;
  logic                  in_list;
  logic                  above_pos;
  logic                  at_pos;

  always_comb begin
    in_list   = IDX < 32'(ctrl.count);
    above_pos = IDX > 32'(ctrl.pos);
    at_pos    = IDX == 32'(ctrl.pos);
    data_next = data;
    if (ctrl.shift_up) begin
      if (above_pos) begin
        data_next = left_data;
      end else if (at_pos) begin
        data_next = val;
      end
    end else if (ctrl.shift_down) begin
      if (above_pos || at_pos) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctrl.capture) begin
      match <= (ctrl.cmd == ole_pkg::CMD_FIND) && in_list && (data == val);
      rd    <= ((ctrl.cmd == ole_pkg::CMD_READ) && in_list && at_pos) ? data
                                                                      : '0;
    end
  end

endmodule

// File: rtl/core/ordered_list_engine.sv
// Positional list of signed elements held in a chain of DEPTH cells, one
// element per cell. Each input word carries one command: read the element at
// a position, find the lowest position holding a value, insert a value at a
// position (later elements move up one cell), or remove the element at a
// position (later elements move down one cell). Every command gives exactly
// one result word with status, read value, found index and the new length.
// In the cycle a command is accepted every cell shifts and compares against
// the broadcast command at once; once the output register is free, the
// per-cell match flags are priority-encoded and the selected element is
// OR-reduced into the output register. The next command is taken once the
// reduction stage has emptied; a waiting result holds a command in the
// reduction stage and so holds off the input as well until the result word
// is taken. capacity is to be written through capacity_we only while idle;
// the block does not enforce this. It resets to 64 and a value above DEPTH
// acts as DEPTH. Element storage needs no clearing after reset: only
// positions below the length are ever read.
module ordered_list_engine #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic signed [6:0]  found_index,
  output logic [6:0]         length,
  input  logic               capacity_we,
  input  logic [6:0]         capacity
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration and list length
  logic [6:0]            cap;
  logic [6:0]            eff_cap;
  logic [6:0]            count;
  logic [6:0]            count_next;

  // Decode of the word on the input channel
  ole_pkg::cmd_t         cmd;
  logic                  accept;
  logic                  insert_ok;
  logic                  remove_ok;
  logic [2:0]            acc_status;
  logic [ELEM_WIDTH-1:0] val_elem;
  ole_pkg::cell_ctrl_t   ctrl;

  // Reduction stage
  logic                  s1_valid;
  ole_pkg::cmd_t         s1_cmd;
  logic [2:0]            s1_status;
  logic                  s1_move;

  // Cell chain
  logic [ELEM_WIDTH-1:0] data_chain [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_vec     [DEPTH];
  logic [DEPTH-1:0]      match_vec;

  // Reduction logic
  logic [DEPTH-1:0]      lowest;
  logic [IW-1:0]         hit_idx;
  logic [ELEM_WIDTH-1:0] rd_or;
  logic signed [ELEM_WIDTH-1:0] rd_signed;
  logic [2:0]            fin_status;
  logic [6:0]            fin_index;

  assign cmd      = ole_pkg::cmd_t'(command);
  assign in_ready = !s1_valid;
  assign accept   = in_valid && in_ready;
  assign val_elem = ELEM_WIDTH'(value);
  assign eff_cap  = (32'(cap) > 32'(DEPTH)) ? 7'(DEPTH) : cap;

  // Bounds checks; full is tested before the position on insert
  always_comb begin
    insert_ok = (cmd == ole_pkg::CMD_INSERT) && (count < eff_cap) && (position <= count);
    remove_ok = (cmd == ole_pkg::CMD_REMOVE) && (count != 7'd0) && (position < count);
    case (cmd)
      ole_pkg::CMD_READ: begin
        acc_status = (position < count) ? ole_pkg::ST_OK : ole_pkg::ST_BADPOS;
      end
      ole_pkg::CMD_FIND: begin
        acc_status = ole_pkg::ST_OK;  // settled by the reduction stage
      end
      ole_pkg::CMD_INSERT: begin
        if (count >= eff_cap) begin
          acc_status = ole_pkg::ST_FULL;
        end else if (position > count) begin
          acc_status = ole_pkg::ST_BADPOS;
        end else begin
          acc_status = ole_pkg::ST_OK;
        end
      end
      ole_pkg::CMD_REMOVE: begin
        if (count == 7'd0) begin
          acc_status = ole_pkg::ST_EMPTY;
        end else if (position >= count) begin
          acc_status = ole_pkg::ST_BADPOS;
        end else begin
          acc_status = ole_pkg::ST_OK;
        end
      end
      default: begin
        acc_status = ole_pkg::ST_BADPOS;
      end
    endcase

    count_next = count;
    if (accept && insert_ok) begin
      count_next = count + 7'd1;
    end else if (accept && remove_ok) begin
      count_next = count - 7'd1;
    end

    ctrl.capture    = accept;
    ctrl.cmd        = cmd;
    ctrl.pos        = position;
    ctrl.count      = count;
    ctrl.shift_up   = accept && insert_ok;
    ctrl.shift_down = accept && remove_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= 7'd64;
      count <= 7'd0;
    end else begin
      if (capacity_we) begin
        cap <= capacity;
      end
      count <= count_next;
    end
  end

  // Cell chain: each cell sees its lower and upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_d;
    logic [ELEM_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = val_elem;  // never taken: cell 0 is never above the position
    end else begin : g_mid_l
      assign left_d = data_chain[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = data_chain[i];  // top cell falls out of the list on remove
    end else begin : g_mid_r
      assign right_d = data_chain[i+1];
    end

    ole_cell #(
      .INDEX      (i),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .val        (val_elem),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (data_chain[i]),
      .match      (match_vec[i]),
      .rd         (rd_vec[i])
    );
  end

  // Reduction: isolate the lowest match, encode it, OR the selected element
  always_comb begin
    lowest  = match_vec & ((~match_vec) + DEPTH'(1));
    hit_idx = '0;
    rd_or   = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (lowest[j]) begin
        hit_idx = hit_idx | IW'(j);
      end
      rd_or = rd_or | rd_vec[j];
    end
    rd_signed = rd_or;

    fin_status = s1_status;
    fin_index  = 7'h7F;
    if (s1_cmd == ole_pkg::CMD_FIND) begin
      if (|match_vec) begin
        fin_status = ole_pkg::ST_OK;
        fin_index  = 7'(hit_idx);
      end else begin
        fin_status = ole_pkg::ST_NOTFOUND;
      end
    end
  end

  // Advance the reduction stage into the output register when it is free
  assign s1_move = s1_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the command beside the cells, then the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= cmd;
      s1_status <= acc_status;
    end
    if (s1_move) begin
      status      <= fin_status;
      read_value  <= 32'(rd_signed);
      found_index <= fin_index;
      length      <= count;
    end
  end

endmodule

// File: rtl/core/ole_checker.sv
module ole_checker #(
  parameter int DEPTH = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         status,
  input logic signed [31:0] read_value,
  input logic signed [6:0]  found_index,
  input logic [6:0]         length
);

  // Hold a result word until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(length))
    else $error("result word dropped or changed while stalled");

  // One command at a time: no word taken in the cycle after one is accepted
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a command is in flight");

  // Length never exceeds the store
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(length) <= 32'(DEPTH))
    else $error("length beyond store depth");

  // A failed command reads back zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ole_pkg::ST_OK) |-> read_value == 32'sd0)
    else $error("non-zero read value on failed command");

  // A miss reports index minus one
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ole_pkg::ST_NOTFOUND) |-> found_index == -7'sd1)
    else $error("miss without index minus one");

endmodule

bind ordered_list_engine ole_checker #(.DEPTH(DEPTH)) u_ole_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .read_value  (read_value),
  .found_index (found_index),
  .length      (length)
);
